// ----- src/phvc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package phvc_pkg;

	// command codes
	localparam logic [1:0] CMD_POS  = 2'd0;
	localparam logic [1:0] CMD_TGT  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// register indexes
	localparam logic [1:0] REG_GAIN     = 2'd0;
	localparam logic [1:0] REG_HSPEED   = 2'd1;
	localparam logic [1:0] REG_TOL      = 2'd2;
	localparam logic [1:0] REG_DEADBAND = 2'd3;

	localparam int GAIN_W = 23;
	localparam int TOL_W  = 17;
	localparam int CFG_W  = 23;

	localparam logic [GAIN_W-1:0] GAIN_RST     = 23'd131072;
	localparam logic [GAIN_W-1:0] HSPEED_RST   = 23'd131072;
	localparam logic [TOL_W-1:0]  TOL_RST      = 17'd6554;
	localparam logic [TOL_W-1:0]  DEADBAND_RST = 17'd655;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic               arrived;
	} out_word_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [GAIN_W-1:0] hspeed_lim;
		logic [TOL_W-1:0]  tol;
		logic [TOL_W-1:0]  deadband;
	} cfg_t;

	typedef logic signed [2:0][31:0] vec3_t;

endpackage

`default_nettype wire

// ----- src/phvc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tick sequencer: one shared multiplier plus restoring shift/subtract steps for
// the square root and the divides, which share the rem/root/shift registers.
module phvc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire phvc_pkg::vec3_t   tgt,
	input  wire phvc_pkg::vec3_t   pos,
	input  wire phvc_pkg::cfg_t    cfg,
	output logic                   idle,
	output logic                   done,
	input  wire logic              ack,
	output phvc_pkg::out_word_t    result
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ERR  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_MULV = 4'd3;
	localparam logic [3:0] ST_VSAT = 4'd4;
	localparam logic [3:0] ST_SQX  = 4'd5;
	localparam logic [3:0] ST_SQY  = 4'd6;
	localparam logic [3:0] ST_SUM  = 4'd7;
	localparam logic [3:0] ST_CMP  = 4'd8;
	localparam logic [3:0] ST_SQRT = 4'd9;
	localparam logic [3:0] ST_DIVM = 4'd10;
	localparam logic [3:0] ST_DIVL = 4'd11;
	localparam logic [3:0] ST_DIV  = 4'd12;
	localparam logic [3:0] ST_DONE = 4'd13;

	logic [3:0]       state_q;
	logic [1:0]       axis_q;
	logic [4:0]       cnt_q;
	logic [2:0][32:0] errmag_q;
	logic [2:0]       errneg_q;
	logic [2:0]       dead_q;
	logic             near_q;
	logic [2:0][31:0] vmag_q;
	logic [2:0]       vneg_q;
	logic             arrived_q;
	logic [64:0]      prod_q;
	logic [63:0]      acc_q;
	logic [63:0]      sh_q;
	logic [34:0]      rem_q;
	logic [31:0]      root_q;
	logic [31:0]      h_q;

	// shared multiplier operands
	logic [32:0] mul_a;
	logic [31:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MULV: begin
				mul_a = errmag_q[axis_q];
				mul_b = {9'd0, cfg.gain};
			end
			ST_SQX: begin
				mul_a = {1'b0, vmag_q[0]};
				mul_b = vmag_q[0];
			end
			ST_SQY: begin
				mul_a = {1'b0, vmag_q[1]};
				mul_b = vmag_q[1];
			end
			ST_SUM: begin
				mul_a = {10'd0, cfg.hspeed_lim};
				mul_b = {9'd0, cfg.hspeed_lim};
			end
			ST_DIVM: begin
				mul_a = {1'b0, vmag_q[axis_q]};
				mul_b = {9'd0, cfg.hspeed_lim};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// error of the selected axis
	logic [32:0] diff;
	logic [32:0] dmag;
	assign diff = {tgt[axis_q][31], tgt[axis_q]} - {pos[axis_q][31], pos[axis_q]};
	assign dmag = diff[32] ? (33'd0 - diff) : diff;

	// rounded axis velocity and its saturation limit
	logic [55:0] rnd;
	logic [39:0] qv;
	logic [39:0] vlim;
	assign rnd  = prod_q[55:0] + 56'h8000;
	assign qv   = rnd[55:16];
	assign vlim = errneg_q[axis_q] ? 40'h0080000000 : 40'h007fffffff;

	// square root step: two bits of S per cycle
	logic [34:0] sq_rem2;
	logic [34:0] sq_trial;
	logic        sq_ge;
	logic [31:0] sq_root_nx;
	assign sq_rem2    = {rem_q[32:0], sh_q[63:62]};
	assign sq_trial   = {1'b0, root_q, 2'b01};
	assign sq_ge      = (sq_rem2 >= sq_trial);
	assign sq_root_nx = {root_q[30:0], sq_ge};

	// divide step: one quotient bit per cycle
	logic [32:0] dv_rem2;
	logic        dv_ge;
	logic [32:0] dv_diff;
	logic [31:0] dv_quo_nx;
	logic [63:0] num;
	assign dv_rem2   = {rem_q[31:0], sh_q[63]};
	assign dv_ge     = (dv_rem2 >= {1'b0, h_q});
	assign dv_diff   = dv_rem2 - {1'b0, h_q};
	assign dv_quo_nx = {root_q[30:0], dv_ge};
	assign num       = prod_q[63:0] + {33'd0, h_q[31:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			axis_q    <= '0;
			cnt_q     <= '0;
			near_q    <= 1'b0;
			arrived_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						axis_q  <= '0;
						near_q  <= 1'b1;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					if (dmag >= {16'd0, cfg.tol}) near_q <= 1'b0;
					axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					if (axis_q == 2'd2) state_q <= ST_CHK;
				end
				ST_CHK: begin
					arrived_q <= near_q;
					state_q   <= near_q ? ST_DONE : ST_MULV;
				end
				ST_MULV: begin
					state_q <= ST_VSAT;
				end
				ST_VSAT: begin
					axis_q  <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					state_q <= (axis_q == 2'd2) ? ST_SQX : ST_MULV;
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					cnt_q   <= '0;
					axis_q  <= '0;
					state_q <= (sh_q > prod_q[63:0]) ? ST_SQRT : ST_DONE;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= ST_DIVM;
				end
				ST_DIVM: begin
					state_q <= ST_DIVL;
				end
				ST_DIVL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						axis_q  <= 2'd1;
						state_q <= (axis_q == 2'd0) ? ST_DIVM : ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ERR: begin
				errmag_q[axis_q] <= dmag;
				errneg_q[axis_q] <= diff[32];
				dead_q[axis_q]   <= (dmag < {16'd0, cfg.deadband});
			end
			ST_CHK: begin
				if (near_q) begin
					vmag_q <= '0;
					vneg_q <= '0;
				end
			end
			ST_VSAT: begin
				vneg_q[axis_q] <= errneg_q[axis_q];
				if (dead_q[axis_q]) vmag_q[axis_q] <= '0;
				else if (qv > vlim) vmag_q[axis_q] <= vlim[31:0];
				else vmag_q[axis_q] <= qv[31:0];
			end
			ST_SQY: begin
				acc_q <= prod_q[63:0];
			end
			ST_SUM: begin
				sh_q <= acc_q + prod_q[63:0];
			end
			ST_CMP: begin
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
				root_q <= sq_root_nx;
				sh_q   <= {sh_q[61:0], 2'b00};
				if (cnt_q == 5'd31) h_q <= sq_root_nx;
			end
			ST_DIVL: begin
				rem_q  <= {3'd0, num[63:32]};
				sh_q   <= {num[31:0], 32'd0};
				root_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= {2'd0, (dv_ge ? dv_diff : dv_rem2)};
				root_q <= dv_quo_nx;
				sh_q   <= {sh_q[62:0], 1'b0};
				if (cnt_q == 5'd31) vmag_q[axis_q] <= dv_quo_nx;
			end
			default: begin
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);

	assign result.vel_x   = vneg_q[0] ? (32'sd0 - $signed(vmag_q[0])) : $signed(vmag_q[0]);
	assign result.vel_y   = vneg_q[1] ? (32'sd0 - $signed(vmag_q[1])) : $signed(vmag_q[1]);
	assign result.vel_z   = vneg_q[2] ? (32'sd0 - $signed(vmag_q[2])) : $signed(vmag_q[2]);
	assign result.arrived = arrived_q;

endmodule

`default_nettype wire

// ----- src/position_hold_velocity_controller_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Update words are accepted whenever the core is idle. A tick gives its output word
// once the core finishes: directly when arrived, after the velocity and clamp test
// without the clamp, and with it after a 32-step square root, then a 32-step divide
// for x and for y; in_ready stays low until the word is loaded into the output register.
// arst_n clears positions, target, the initialized flag and out_valid; the
// configuration registers return to their default values.
module position_hold_velocity_controller_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire phvc_pkg::in_word_t         in_word,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output phvc_pkg::out_word_t             out_word,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_idx,
	input  wire logic [phvc_pkg::CFG_W-1:0] cfg_wdata
);

	// configuration registers
	phvc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain       <= phvc_pkg::GAIN_RST;
			cfg_q.hspeed_lim <= phvc_pkg::HSPEED_RST;
			cfg_q.tol        <= phvc_pkg::TOL_RST;
			cfg_q.deadband   <= phvc_pkg::DEADBAND_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				phvc_pkg::REG_GAIN:     cfg_q.gain       <= cfg_wdata;
				phvc_pkg::REG_HSPEED:   cfg_q.hspeed_lim <= cfg_wdata;
				phvc_pkg::REG_TOL:      cfg_q.tol        <= cfg_wdata[phvc_pkg::TOL_W-1:0];
				phvc_pkg::REG_DEADBAND: cfg_q.deadband   <= cfg_wdata[phvc_pkg::TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// position / target state
	phvc_pkg::vec3_t pos_q;
	phvc_pkg::vec3_t tgt_q;
	logic            init_q;
	phvc_pkg::vec3_t in_vec;

	logic core_idle;
	logic core_done;
	logic core_ack;
	logic accept;
	logic tick_start;
	phvc_pkg::out_word_t core_res;

	assign in_vec     = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
	assign in_ready   = core_idle;
	assign accept     = in_valid && in_ready;
	// a tick before the first position update is dropped with no word out
	assign tick_start = accept && (in_word.command == phvc_pkg::CMD_TICK) && init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tgt_q  <= '0;
			init_q <= 1'b0;
		end else if (accept) begin
			case (in_word.command)
				phvc_pkg::CMD_POS: begin
					pos_q <= in_vec;
					// first fix also becomes the hold point
					if (!init_q) begin
						tgt_q  <= in_vec;
						init_q <= 1'b1;
					end
				end
				phvc_pkg::CMD_TGT: begin
					tgt_q <= in_vec;
				end
				default: begin
				end
			endcase
		end
	end

	phvc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tick_start),
		.tgt    (tgt_q),
		.pos    (pos_q),
		.cfg    (cfg_q),
		.idle   (core_idle),
		.done   (core_done),
		.ack    (core_ack),
		.result (core_res)
	);

	// output register: the core parks in its done state until the word can be loaded
	logic                out_valid_q;
	phvc_pkg::out_word_t out_word_q;

	assign core_ack = core_done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ack) out_word_q <= core_res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire
